// ===== rtl/isort_pkg.sv =====
// Shared constants, types and state codes of the insertion sorter.
package isort_pkg;

   localparam int DEPTH  = 64;
   localparam int DATA_W = 32;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } store_wr_type;

   typedef enum logic [7:0] {
      ST_LOAD     = 8'b0000_0001,
      ST_KEY_RD   = 8'b0000_0010,
      ST_KEY_WT   = 8'b0000_0100,
      ST_CMP      = 8'b0000_1000,
      ST_PLACE    = 8'b0001_0000,
      ST_OUT_RD   = 8'b0010_0000,
      ST_OUT_LD   = 8'b0100_0000,
      ST_OUT_WAIT = 8'b1000_0000
   } state_type;

endpackage

// ===== rtl/isort_if.sv =====
// Valid/ready channels for the sorter's input elements and sorted results.
interface isort_req_if import isort_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] value;
   logic                     last_item;

   modport source (output valid, output value, output last_item, input ready);
   modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface isort_rsp_if import isort_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sorted_value;
   logic                     last_of_run;
   logic                     overflow;

   modport source (output valid, output sorted_value, output last_of_run, output overflow,
                   input ready);
   modport sink   (input valid, input sorted_value, input last_of_run, input overflow,
                   output ready);
endinterface

// ===== rtl/isort_store.sv =====
// Element store: one write port, one read port with registered read data.
module isort_store import isort_pkg::*; (
   input  logic              clock,
   input  store_wr_type      wr,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/insertion_sorter_core.sv =====
// Insertion sorter: loads a set, sorts it in place in a store, then streams it out.
// Load: one element per cycle while no set is being sorted or emitted.
// Sort: the first key is read, then each key is fetched and compared with its predecessors,
// each greater one shifted up one place, and the key written into the gap; the sort is paced by the
// store's one read port and the single compare unit. Emit: one result at a time, each held until rsp ready.
// Reset (synchronous): store empty, drop flag clear, ready for the first element.
module insertion_sorter_core import isort_pkg::*; (
   input  logic clock,
   input  logic reset,
   isort_req_if.sink   req_ch,
   isort_rsp_if.source rsp_ch
);

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic                     drop_ff, drop_in;
   logic [ADDR_W-1:0]        idx_ff, idx_in;
   logic [ADDR_W-1:0]        pos_ff, pos_in;
   logic [ADDR_W-1:0]        out_ff, out_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic signed [DATA_W-1:0] res_ff, res_in;
   logic                     res_last_ff, res_last_in;
   logic                     res_ovf_ff, res_ovf_in;

   store_wr_type             wr;
   logic [ADDR_W-1:0]        rd_addr;
   logic [DATA_W-1:0]        rd_data;
   logic                     full;
   logic                     greater;
   logic                     last_key;
   logic                     last_out;

   isort_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign greater  = ($signed(rd_data) > key_ff);
   assign last_key = ((CNT_W'(idx_ff) + CNT_W'(1)) == fill_ff);
   assign last_out = ((CNT_W'(out_ff) + CNT_W'(1)) == fill_ff);

   assign req_ch.ready        = (state_ff == ST_LOAD);
   assign rsp_ch.valid        = (state_ff == ST_OUT_WAIT);
   assign rsp_ch.sorted_value = res_ff;
   assign rsp_ch.last_of_run  = res_last_ff;
   assign rsp_ch.overflow     = res_ovf_ff;

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      drop_in     = drop_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      out_in      = out_ff;
      key_in      = key_ff;
      res_in      = res_ff;
      res_last_in = res_last_ff;
      res_ovf_in  = res_ovf_ff;
      wr.en       = 1'b0;
      wr.addr     = pos_ff;
      wr.data     = key_ff;
      rd_addr     = '0;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_ch.valid) begin
               if (!full) begin
                  wr.en   = 1'b1;
                  wr.addr = fill_ff[ADDR_W-1:0];
                  wr.data = req_ch.value;
                  fill_in = fill_ff + CNT_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_ch.last_item) begin
                  idx_in = ADDR_W'(1);
                  out_in = '0;
                  // a single element needs no sorting
                  if (fill_in == CNT_W'(1)) begin
                     state_in = ST_OUT_RD;
                  end else begin
                     state_in = ST_KEY_RD;
                  end
               end
            end
         end
         ST_KEY_RD: begin
            rd_addr  = idx_ff;
            state_in = ST_KEY_WT;
         end
         ST_KEY_WT: begin
            key_in   = rd_data;
            pos_in   = idx_ff;
            rd_addr  = idx_ff - ADDR_W'(1);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            wr.en = 1'b1;
            if (greater) begin
               // shift predecessor up one place, fetch the next one down
               wr.data = rd_data;
               pos_in  = pos_ff - ADDR_W'(1);
               rd_addr = pos_ff - ADDR_W'(2);
               if (pos_ff == ADDR_W'(1)) begin
                  state_in = ST_PLACE;
               end
            end else if (last_key) begin
               state_in = ST_OUT_RD;
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               rd_addr  = idx_ff + ADDR_W'(1);
               state_in = ST_KEY_WT;
            end
         end
         ST_PLACE: begin
            wr.en = 1'b1;
            if (last_key) begin
               state_in = ST_OUT_RD;
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               rd_addr  = idx_ff + ADDR_W'(1);
               state_in = ST_KEY_WT;
            end
         end
         ST_OUT_RD: begin
            rd_addr  = out_ff;
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            res_in      = rd_data;
            res_last_in = last_out;
            res_ovf_in  = last_out & drop_ff;
            state_in    = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (rsp_ch.ready) begin
               if (res_last_ff) begin
                  fill_in  = '0;
                  drop_in  = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  out_in   = out_ff + ADDR_W'(1);
                  rd_addr  = out_ff + ADDR_W'(1);
                  state_in = ST_OUT_LD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         fill_ff  <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      out_ff      <= out_in;
      key_ff      <= key_in;
      res_ff      <= res_in;
      res_last_ff <= res_last_in;
      res_ovf_ff  <= res_ovf_in;
   end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for insertion_sorter_core: random and directed sets, sorted values and flags checked.
`timescale 1ns / 1ps

module testbench import isort_pkg::*; ();

   typedef logic signed [DATA_W-1:0] elem_type;
   typedef elem_type elem_q_type[$];

   typedef struct {
      elem_type value;
      logic     last_of_run;
      logic     overflow;
   } sorted_beat_type;

   localparam elem_type VAL_MIN     = 32'sh8000_0000;
   localparam elem_type VAL_MAX     = 32'sh7FFF_FFFF;
   localparam int       STALL_LIMIT = 20000;
   localparam int       SETTLE_CYCLES = 100;

   logic clock;
   logic reset;

   isort_req_if req_ch ();
   isort_rsp_if rsp_ch ();

   insertion_sorter_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // predictor state and run statistics
   elem_q_type      loading_set;
   bit              loading_dropped;
   sorted_beat_type sorted_pending[$];
   int              error_count;
   int              results_checked;
   int              elements_sent;
   int              sets_closed;
   int              overflow_sets;
   int              req_idle_pct;
   int              rsp_idle_pct;
   int              rsp_hold_cycles;
   int              quiet_cycles;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("MISMATCH result %0d %s: got %h, want %h", results_checked, what, got, want);
      error_count++;
   endtask

   // Stable insertion sort of one closed set, then queue its beats in output order.
   function automatic void predict_sorted_run(input elem_q_type stored, input bit dropped);
      int              pos;
      elem_type        key;
      sorted_beat_type beat;
      for (int i = 1; i < stored.size(); i++) begin
         key = stored[i];
         pos = i;
         while (pos > 0 && stored[pos-1] > key) begin
            stored[pos] = stored[pos-1];
            pos--;
         end
         stored[pos] = key;
      end
      for (int k = 0; k < stored.size(); k++) begin
         beat.value       = stored[k];
         beat.last_of_run = (k == stored.size() - 1);
         beat.overflow    = beat.last_of_run && dropped;
         sorted_pending.push_back(beat);
      end
   endfunction

   // Track accepted elements; a set closes on the beat marked last.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         if (loading_set.size() < DEPTH)
            loading_set.push_back(req_ch.value);
         else
            loading_dropped = 1'b1;
         if (req_ch.last_item) begin
            predict_sorted_run(loading_set, loading_dropped);
            sets_closed++;
            if (loading_dropped)
               overflow_sets++;
            loading_set.delete();
            loading_dropped = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      sorted_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (sorted_pending.size() == 0) begin
            report_mismatch("unexpected beat", rsp_ch.sorted_value, '0);
         end else begin
            want = sorted_pending.pop_front();
            if (rsp_ch.sorted_value !== want.value)
               report_mismatch("sorted_value", rsp_ch.sorted_value, want.value);
            if (rsp_ch.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", DATA_W'(rsp_ch.last_of_run),
                               DATA_W'(want.last_of_run));
            if (rsp_ch.overflow !== want.overflow)
               report_mismatch("overflow", DATA_W'(rsp_ch.overflow), DATA_W'(want.overflow));
         end
         results_checked++;
      end
   end

   // Result side: long hold-off when requested, otherwise random stalls.
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold_cycles = rsp_hold_cycles - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
         $display("insertion_sorter_core verification failed");
         $finish;
      end
   end

   // Offer one element; return at the edge that accepts it, valid left high.
   task automatic send_element(input elem_type value, input logic last_item);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct)
         gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.value     <= value;
      req_ch.last_item <= last_item;
      do
         @(posedge clock);
      while (!req_ch.ready);
      elements_sent++;
   endtask

   task automatic send_set(input elem_q_type vals);
      for (int i = 0; i < vals.size(); i++)
         send_element(vals[i], i == vals.size() - 1);
   endtask

   task automatic release_req();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      release_req();
      while (sorted_pending.size() != 0)
         @(posedge clock);
   endtask

   function automatic elem_type random_element();
      int offset;
      offset = $urandom_range(16);
      case ($urandom_range(3))
         0: return elem_type'(offset - 8);
         1: return ($urandom_range(1) != 0) ? VAL_MAX - elem_type'(offset)
                                            : VAL_MIN + elem_type'(offset);
         default: return elem_type'($urandom);
      endcase
   endfunction

   function automatic elem_q_type random_set(input int count);
      elem_q_type vals;
      for (int i = 0; i < count; i++)
         vals.push_back(random_element());
      return vals;
   endfunction

   // Extremes, single element, duplicates, presorted and reversed sets.
   task automatic test_directed_sets();
      elem_q_type vals;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      vals = {elem_type'(0)};
      send_set(vals);
      vals = {VAL_MAX, VAL_MIN};
      send_set(vals);
      vals = {elem_type'(-1), elem_type'(1), elem_type'(0), VAL_MIN, VAL_MAX, VAL_MAX - 1,
              VAL_MIN + 1};
      send_set(vals);
      vals = {elem_type'(5), elem_type'(5), elem_type'(-5), elem_type'(5), elem_type'(-5)};
      send_set(vals);
      vals = {elem_type'(1), elem_type'(2), elem_type'(3), elem_type'(4)};
      send_set(vals);
      vals = {elem_type'(9), elem_type'(8), elem_type'(7), elem_type'(-6)};
      send_set(vals);
      wait_drained();
   endtask

   // Exactly full, then three elements past capacity, all three dropped.
   task automatic test_store_full();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_set(random_set(DEPTH));
      wait_drained();
      send_set(random_set(DEPTH + 3));
      wait_drained();
   endtask

   // Hold the result side off while further sets wait at the input behind the emitting one.
   task automatic test_result_backpressure();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      rsp_hold_cycles = 400;
      send_set(random_set(10));
      send_set(random_set(6));
      send_set(random_set(3));
      wait_drained();
   endtask

   task automatic test_random_sets(input int target, input int send_pct, input int recv_pct);
      int sent;
      int count;
      req_idle_pct = send_pct;
      rsp_idle_pct = recv_pct;
      sent = 0;
      while (sent < target) begin
         count = $urandom_range(1, 12);
         if (count > target - sent)
            count = target - sent;
         send_set(random_set(count));
         sent += count;
         // pause now and then until the block has emptied
         if ($urandom_range(3) == 0)
            wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.value     = '0;
      req_ch.last_item = 1'b0;
      rsp_ch.ready     = 1'b0;
      loading_dropped  = 1'b0;
      error_count      = 0;
      results_checked  = 0;
      elements_sent    = 0;
      sets_closed      = 0;
      overflow_sets    = 0;
      req_idle_pct     = 0;
      rsp_idle_pct     = 0;
      rsp_hold_cycles  = 0;
      quiet_cycles     = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_random_sets(18, 16, 78);
      test_random_sets(18, 78, 16);
      test_directed_sets();
      test_store_full();
      test_result_backpressure();
      test_random_sets(18, 0, 0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d elements in %0d sets (%0d past capacity), checked %0d sorted beats",
               elements_sent, sets_closed, overflow_sets, results_checked);
      $display("Idle mixes: sender 16%%/receiver 78%%, reversed, none; plus a long result hold-off");
      if (error_count == 0 && sorted_pending.size() == 0) begin
         $display("insertion_sorter_core verification clean");
      end else begin
         $display("%0d mismatches, %0d beats still pending", error_count, sorted_pending.size());
         $display("insertion_sorter_core verification failed");
      end
      $finish;
   end

endmodule
